// ===== design/pli_pkg.sv =====
// shared constants and codes for the posting list intersection core
// no dependencies
package pli_pkg;

    // default number of entries per stored list
    localparam int LIST_DEPTH_DEF = 64;

    // width of one document number
    localparam int DOC_W = 31;

    // action codes carried on s_tuser
    typedef enum logic [1:0] {
        ACT_PUSH_A = 2'd0,
        ACT_PUSH_B = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_NONE   = 2'd3
    } pli_action_t;

endpackage

// ===== design/pli_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module pli_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/pli_isqrt.sv =====
// integer square root unit, one result bit per cycle from the top bit down
// no dependencies
module pli_isqrt #(
    parameter int CW = 7,
    parameter int GW = (CW + 1) / 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [CW-1:0] n_in,
    output logic          busy,
    output logic [GW-1:0] root
);

    localparam int SQW = 2 * GW;
    localparam int IW  = $clog2(GW + 1);

    logic          busy_reg, busy_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [GW-1:0] root_reg, root_next;
    logic [CW-1:0] n_reg, n_next;
    logic [GW-1:0] trial;
    logic [SQW-1:0] trial_sq;

    // try the next bit of the root
    assign trial    = root_reg | (GW'(1) << (idx_reg - IW'(1)));
    assign trial_sq = SQW'(trial) * SQW'(trial);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        root_next = root_reg;
        n_next    = n_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = IW'(GW);
            root_next = '0;
            n_next    = n_in;
        end else if (busy_reg) begin
            if (trial_sq <= SQW'(n_reg)) begin
                root_next = trial;
            end
            idx_next = idx_reg - IW'(1);
            if (idx_reg == IW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        root_reg <= root_next;
        n_reg    <= n_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== design/posting_list_intersect_core.sv =====
// posting list intersection core: two list rams, a skip walk sequencer and
// an output register with a one-item hold for last marking
// depends on pli_pkg, pli_ram, pli_isqrt
// push items are accepted back to back while idle; a run computes the square
// roots of both counts, then steps through read and compare per compare step,
// jump read and jump compare per skip probe, a match state per match and a finish
// state; the walk also waits while the output register is held by m_tready low
// synchronous active-low reset clears counts, overflow flag and control; the
// list rams are not cleared and need no clearing pass
module posting_list_intersect_core
    import pli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: doc_number [30:0], zero [31]
    input  logic [31:0] s_tdata,
    // s_tuser: action [1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: doc_number_res [30:0], zero [31]
    output logic [31:0] m_tdata,
    // m_tuser: is_empty [0], overflowed [1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int GW = (CW + 1) / 2;
    localparam int SW = CW + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_RD,
        ST_CMP,
        ST_JRD_A,
        ST_JCMP_A,
        ST_JRD_B,
        ST_JCMP_B,
        ST_MATCH,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    pa_reg, pa_next, pb_reg, pb_next;
    logic [GW-1:0]    ska_reg, ska_next, skb_reg, skb_next;
    logic             jmp_reg, jmp_next;
    logic [DOC_W-1:0] ea_reg, ea_next, eb_reg, eb_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [DOC_W-1:0] pend_num_reg, pend_num_next;
    logic             out_valid_reg, out_valid_next;
    logic [DOC_W-1:0] out_num_reg, out_num_next;
    logic             out_empty_reg, out_empty_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             s_accept;
    pli_action_t      action;
    logic [DOC_W-1:0] doc_in;
    logic             we_a, we_b;
    logic [AW-1:0]    raddr_a, raddr_b;
    logic [DOC_W-1:0] rdata_a, rdata_b;
    logic             sqrt_start, busy_a, busy_b;
    logic [GW-1:0]    ga, gb;
    logic             out_free;
    logic [SW-1:0]    ja_sum, jb_sum, jja_sum, jjb_sum, pa_inc, pb_inc;
    logic [GW:0]      ska_inc, skb_inc;
    logic             can_a, can_b, more_a, more_b;

    assign action   = pli_action_t'(s_tuser);
    assign doc_in   = s_tdata[DOC_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // push writes go to the entry at the fill count
    assign we_a = s_accept && (action == ACT_PUSH_A) && (cnt_a_reg < CW'(LIST_DEPTH));
    assign we_b = s_accept && (action == ACT_PUSH_B) && (cnt_b_reg < CW'(LIST_DEPTH));
    assign sqrt_start = s_accept && (action == ACT_RUN);

    // cursor arithmetic for step and skip
    assign ja_sum  = SW'(pa_reg) + SW'(ga);
    assign jb_sum  = SW'(pb_reg) + SW'(gb);
    assign jja_sum = ja_sum + SW'(ga);
    assign jjb_sum = jb_sum + SW'(gb);
    assign pa_inc  = SW'(pa_reg) + SW'(1);
    assign pb_inc  = SW'(pb_reg) + SW'(1);
    assign ska_inc = (GW + 1)'(ska_reg) + (GW + 1)'(1);
    assign skb_inc = (GW + 1)'(skb_reg) + (GW + 1)'(1);
    assign can_a   = (ska_reg == '0) && (ja_sum < SW'(cnt_a_reg));
    assign can_b   = (skb_reg == '0) && (jb_sum < SW'(cnt_b_reg));
    assign more_a  = pa_inc < SW'(cnt_a_reg);
    assign more_b  = pb_inc < SW'(cnt_b_reg);

    // read addresses: skip target while probing, cursor otherwise
    assign raddr_a = (state_reg == ST_JRD_A) ? ja_sum[AW-1:0] : pa_reg[AW-1:0];
    assign raddr_b = (state_reg == ST_JRD_B) ? jb_sum[AW-1:0] : pb_reg[AW-1:0];

    pli_ram #(.WIDTH(DOC_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (doc_in),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    pli_ram #(.WIDTH(DOC_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (doc_in),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    pli_isqrt #(.CW(CW), .GW(GW)) u_sqrt_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .n_in    (cnt_a_reg),
        .busy    (busy_a),
        .root    (ga)
    );

    pli_isqrt #(.CW(CW), .GW(GW)) u_sqrt_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .n_in    (cnt_b_reg),
        .busy    (busy_b),
        .root    (gb)
    );

    // walk sequencer and output staging
    always_comb begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        ovf_next        = ovf_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        ska_next        = ska_reg;
        skb_next        = skb_reg;
        jmp_next        = jmp_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        pend_valid_next = pend_valid_reg;
        pend_num_next   = pend_num_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        out_num_next    = out_num_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (action)
                        ACT_PUSH_A: begin
                            if (we_a) begin
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_PUSH_B: begin
                            if (we_b) begin
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_RUN: begin
                            pa_next         = '0;
                            pb_next         = '0;
                            ska_next        = '0;
                            skb_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SQRT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SQRT: begin
                if (!busy_a && !busy_b) begin
                    if (cnt_a_reg == '0 || cnt_b_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                ea_next  = rdata_a;
                eb_next  = rdata_b;
                jmp_next = 1'b0;
                if (rdata_a == rdata_b) begin
                    state_next = ST_MATCH;
                end else if (rdata_a < rdata_b) begin
                    if (can_a) begin
                        state_next = ST_JRD_A;
                    end else begin
                        pa_next    = pa_inc[CW-1:0];
                        ska_next   = (ska_inc == (GW + 1)'(ga)) ? '0 : ska_inc[GW-1:0];
                        state_next = more_a ? ST_RD : ST_FINISH;
                    end
                end else begin
                    if (can_b) begin
                        state_next = ST_JRD_B;
                    end else begin
                        pb_next    = pb_inc[CW-1:0];
                        skb_next   = (skb_inc == (GW + 1)'(gb)) ? '0 : skb_inc[GW-1:0];
                        state_next = more_b ? ST_RD : ST_FINISH;
                    end
                end
            end
            ST_JRD_A: begin
                state_next = ST_JCMP_A;
            end
            ST_JCMP_A: begin
                if (rdata_a <= eb_reg) begin
                    pa_next    = ja_sum[CW-1:0];
                    jmp_next   = 1'b1;
                    state_next = (jja_sum < SW'(cnt_a_reg)) ? ST_JRD_A : ST_RD;
                end else if (jmp_reg) begin
                    state_next = ST_RD;
                end else begin
                    pa_next    = pa_inc[CW-1:0];
                    ska_next   = (ska_inc == (GW + 1)'(ga)) ? '0 : ska_inc[GW-1:0];
                    state_next = more_a ? ST_RD : ST_FINISH;
                end
            end
            ST_JRD_B: begin
                state_next = ST_JCMP_B;
            end
            ST_JCMP_B: begin
                if (rdata_b <= ea_reg) begin
                    pb_next    = jb_sum[CW-1:0];
                    jmp_next   = 1'b1;
                    state_next = (jjb_sum < SW'(cnt_b_reg)) ? ST_JRD_B : ST_RD;
                end else if (jmp_reg) begin
                    state_next = ST_RD;
                end else begin
                    pb_next    = pb_inc[CW-1:0];
                    skb_next   = (skb_inc == (GW + 1)'(gb)) ? '0 : skb_inc[GW-1:0];
                    state_next = more_b ? ST_RD : ST_FINISH;
                end
            end
            ST_MATCH: begin
                // the held match goes out once a newer one replaces it
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_num_next   = pend_num_reg;
                        out_empty_next = 1'b0;
                        out_last_next  = 1'b0;
                        out_ovf_next   = ovf_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_num_next   = ea_reg;
                    pa_next         = pa_inc[CW-1:0];
                    pb_next         = pb_inc[CW-1:0];
                    ska_next   = (ska_inc == (GW + 1)'(ga)) ? '0 : ska_inc[GW-1:0];
                    skb_next   = (skb_inc == (GW + 1)'(gb)) ? '0 : skb_inc[GW-1:0];
                    state_next = (more_a && more_b) ? ST_RD : ST_FINISH;
                end
            end
            ST_FINISH: begin
                // last item of the run, or the empty marker
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_num_next    = pend_valid_reg ? pend_num_reg : '0;
                    out_empty_next  = !pend_valid_reg;
                    out_last_next   = 1'b1;
                    out_ovf_next    = ovf_reg;
                    pend_valid_next = 1'b0;
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        ska_reg       <= ska_next;
        skb_reg       <= skb_next;
        jmp_reg       <= jmp_next;
        ea_reg        <= ea_next;
        eb_reg        <= eb_next;
        pend_num_reg  <= pend_num_next;
        out_num_reg   <= out_num_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_num_reg};
    assign m_tuser  = {out_ovf_reg, out_empty_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== test/tb_posting_list_intersect_core.sv =====
// testbench for posting_list_intersect_core: directed table then random push/run
// sequences, each result checked against a fixed table value or the in-bench skip-walk predictor
// depends on pli_pkg and posting_list_intersect_core
module tb_posting_list_intersect_core;
    import pli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = LIST_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;
    localparam int STOP_ITEMS = 150;
    localparam int CALM_ITEMS = 125;
    localparam int BIG_START = 30;

    // one result item as seen on the master side
    typedef struct packed {
        logic [30:0] doc;
        logic        is_empty;
        logic        last;
        logic        ovf;
    } result_t;

    // one row of the directed table
    typedef struct packed {
        pli_action_t act;
        logic [30:0] doc;
        bit          fixed;
        result_t     want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = ACT_NONE;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    // predictor copy of the stored lists
    logic [30:0] lst_a [DEPTH];
    logic [30:0] lst_b [DEPTH];
    int unsigned cnt_a = 0;
    int unsigned cnt_b = 0;
    bit          ovf_flag = 1'b0;

    result_t     run_out [$];
    result_t     pending_results [$];
    row_t        dir_rows [$];

    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned errors = 0;

    posting_list_intersect_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned isqrt(input int unsigned n);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= n)
            r++;
        return r;
    endfunction

    function automatic logic [30:0] entry(input bit side_b, input int unsigned idx);
        return side_b ? lst_b[idx] : lst_a[idx];
    endfunction

    function automatic bit jump_ok(input int unsigned pos, input int unsigned gap,
                                   input int unsigned len);
        if (pos >= len || gap == 0)
            return 1'b0;
        return (pos % gap) == 0 && pos + gap < len;
    endfunction

    // next cursor of one list: skip while on a skip point and the target stays <= bound
    function automatic int unsigned skip_fwd(input bit side_b, input int unsigned pos,
                                             input logic [30:0] bound);
        int unsigned len;
        int unsigned gap;
        int unsigned p;
        len = side_b ? cnt_b : cnt_a;
        gap = isqrt(len);
        p = pos;
        if (jump_ok(p, gap, len) && entry(side_b, p + gap) <= bound) begin
            while (jump_ok(p, gap, len) && entry(side_b, p + gap) <= bound)
                p += gap;
            return p;
        end
        return p + 1;
    endfunction

    // update list state for one item, leave the run's results in run_out
    task automatic intersect_model(input pli_action_t act, input logic [30:0] doc);
        int unsigned pa;
        int unsigned pb;
        result_t     r;
        run_out.delete();
        case (act)
            ACT_PUSH_A: begin
                if (cnt_a < DEPTH) begin
                    lst_a[cnt_a] = doc;
                    cnt_a++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            ACT_PUSH_B: begin
                if (cnt_b < DEPTH) begin
                    lst_b[cnt_b] = doc;
                    cnt_b++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            ACT_RUN: begin
                pa = 0;
                pb = 0;
                while (pa < cnt_a && pb < cnt_b) begin
                    if (lst_a[pa] == lst_b[pb]) begin
                        r.doc = lst_a[pa];
                        r.is_empty = 1'b0;
                        r.last = 1'b0;
                        r.ovf = ovf_flag;
                        run_out.push_back(r);
                        pa++;
                        pb++;
                    end else if (lst_a[pa] < lst_b[pb]) begin
                        pa = skip_fwd(1'b0, pa, lst_b[pb]);
                    end else begin
                        pb = skip_fwd(1'b1, pb, lst_a[pa]);
                    end
                end
                // empty answer gives one flagged item, else mark the final one
                if (run_out.size() == 0) begin
                    r.doc = '0;
                    r.is_empty = 1'b1;
                    r.last = 1'b1;
                    r.ovf = ovf_flag;
                end else begin
                    r = run_out.pop_back();
                    r.last = 1'b1;
                end
                run_out.push_back(r);
                cnt_a = 0;
                cnt_b = 0;
                ovf_flag = 1'b0;
            end
            default: ;
        endcase
    endtask

    // drive one item, wait for its handshake, then queue what it should produce
    task automatic send_item(input pli_action_t act, input logic [30:0] doc,
                             input bit fixed, input result_t want);
        int unsigned gap;
        if (items_sent >= CALM_ITEMS)
            idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, doc};
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        intersect_model(act, doc);
        if (fixed) begin
            pending_results.push_back(want);
        end else begin
            foreach (run_out[i])
                pending_results.push_back(run_out[i]);
        end
        if (act != ACT_NONE)
            items_sent++;
    endtask

    function automatic void add_row(input pli_action_t act, input logic [30:0] doc,
                                    input bit fixed, input result_t want);
        row_t row;
        row.act = act;
        row.doc = doc;
        row.fixed = fixed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    // one push/run sequence: n numbers, share percent go to both lists;
    // messy sequences use small or arbitrary values, so lists may repeat or fall
    task automatic run_sequence(input int unsigned n, input int unsigned share,
                                input int unsigned stepmax, input bit messy);
        logic [30:0] va [$];
        logic [30:0] vb [$];
        logic [30:0] v;
        int unsigned cur;
        int unsigned wa;
        cur = $urandom_range(0, 32'h7FFF_FFFF - (n + 1) * stepmax);
        wa = $urandom_range(0, 100);
        for (int i = 0; i < n; i++) begin
            if (messy)
                v = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                : 31'($urandom_range(0, 15));
            else
                v = 31'(cur);
            cur += $urandom_range(1, stepmax);
            if ($urandom_range(0, 99) < share) begin
                va.push_back(v);
                vb.push_back(v);
            end else if ($urandom_range(0, 99) < wa) begin
                va.push_back(v);
            end else begin
                vb.push_back(v);
            end
        end
        // interleave the two lists at random
        while (va.size() != 0 || vb.size() != 0) begin
            if (vb.size() == 0 || (va.size() != 0 && $urandom_range(0, 1) == 1))
                send_item(ACT_PUSH_A, va.pop_front(), 1'b0, '0);
            else
                send_item(ACT_PUSH_B, vb.pop_front(), 1'b0, '0);
        end
        send_item(ACT_RUN, 31'($urandom), 1'b0, '0);
    endtask

    // result side backpressure in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each accepted result item with the oldest pending one
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: doc_number_res %h", m_tdata[30:0]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[30:0] !== want.doc) begin
                    $error("doc_number_res: expected %h, got %h", want.doc, m_tdata[30:0]);
                    errors++;
                end
                if (m_tuser[0] !== want.is_empty) begin
                    $error("is_empty: expected %b, got %b", want.is_empty, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    errors++;
                end
                if (m_tuser[1] !== want.ovf) begin
                    $error("overflowed: expected %b, got %b", want.ovf, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int unsigned kind;
        int unsigned n;
        int unsigned stepmax;
        bit          big_done;
        big_done = 1'b0;

        // directed table: empty run after reset, extremes, ignored code, skips
        add_row(ACT_RUN,    31'h5555_5555, 1'b1, '{31'd0, 1'b1, 1'b1, 1'b0});
        add_row(ACT_PUSH_A, 31'd0,         1'b0, '0);
        add_row(ACT_PUSH_B, 31'd0,         1'b0, '0);
        add_row(ACT_RUN,    31'd0,         1'b1, '{31'd0, 1'b0, 1'b1, 1'b0});
        add_row(ACT_PUSH_A, 31'h7FFF_FFFF, 1'b0, '0);
        add_row(ACT_PUSH_B, 31'h7FFF_FFFF, 1'b0, '0);
        add_row(ACT_NONE,   31'h2AAA_AAAA, 1'b0, '0);
        add_row(ACT_RUN,    31'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, 1'b0, 1'b1, 1'b0});
        add_row(ACT_PUSH_A, 31'd1,         1'b0, '0);
        add_row(ACT_PUSH_B, 31'd2,         1'b0, '0);
        add_row(ACT_RUN,    31'd0,         1'b1, '{31'd0, 1'b1, 1'b1, 1'b0});
        // list a long enough for skips over its smaller entries
        for (int i = 1; i <= 6; i++)
            add_row(ACT_PUSH_A, 31'(2 * i), 1'b0, '0);
        add_row(ACT_PUSH_B, 31'd11,        1'b0, '0);
        add_row(ACT_PUSH_B, 31'd12,        1'b0, '0);
        add_row(ACT_RUN,    31'd0,         1'b0, '0);
        // falling list
        add_row(ACT_PUSH_A, 31'd5,         1'b0, '0);
        add_row(ACT_PUSH_A, 31'd3,         1'b0, '0);
        add_row(ACT_PUSH_B, 31'd3,         1'b0, '0);
        add_row(ACT_RUN,    31'd0,         1'b0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].doc, dir_rows[i].fixed, dir_rows[i].want);

        // random part
        while (items_sent < STOP_ITEMS) begin
            kind = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0: stepmax = 1;
                1: stepmax = 16;
                default: stepmax = 1 << 20;
            endcase
            if (!big_done && items_sent >= BIG_START) begin
                // both lists overfilled, every kept entry common
                big_done = 1'b1;
                run_sequence(65, 100, stepmax, 1'b0);
            end else if (kind < 7) begin
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 70)
                                                 : $urandom_range(0, 14);
                run_sequence(n, $urandom_range(10, 100), stepmax, 1'b0);
            end else if (kind < 9) begin
                run_sequence($urandom_range(0, 12), $urandom_range(0, 60), 1, 1'b1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(pli_action_t'($urandom_range(0, 3)), 31'($urandom),
                              1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
